/* rtl/core/nlt_pkg.sv */
// Shared types and constants for the neighbor liveness table.
`timescale 1ns / 1ps

package nlt_pkg;

    localparam int NLT_ENTRIES = 16;

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEGRADED = 2'd1;
    localparam logic [1:0] ST_DEAD     = 2'd2;

    localparam logic [1:0] CFG_PERIOD_MS       = 2'd0;
    localparam logic [1:0] CFG_DEGRADED_MISSES = 2'd1;
    localparam logic [1:0] CFG_DEAD_MISSES     = 2'd2;

    localparam logic [15:0] PERIOD_MS_RST       = 16'd1000;
    localparam logic [7:0]  DEGRADED_MISSES_RST = 8'd3;
    localparam logic [7:0]  DEAD_MISSES_RST     = 8'd10;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] now_ms;
    } t_nlt_item;

    typedef struct packed {
        logic        is_new;
        logic        found;
        logic [1:0]  entry_state;
        logic [31:0] last_seen;
        logic [4:0]  transitions;
        logic [4:0]  alive_count;
        logic        table_full;
    } t_nlt_result;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] last_seen;
        logic [1:0]  state;
    } t_nlt_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_COMMIT
    } t_nlt_state;

    typedef struct packed {
        logic load;
        logic walk;
        logic commit;
    } t_nlt_cmd;

    typedef struct packed {
        logic rd_last;
    } t_nlt_status;

endpackage

/* rtl/core/nlt_ctrl.sv */
// Sequencer for the table walk: accept, walk, drain, commit.
`timescale 1ns / 1ps

module nlt_ctrl
    import nlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_nlt_status i_status,
    output logic        busy,
    output t_nlt_cmd    o_cmd
);

    t_nlt_state r_state;
    t_nlt_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_status.rd_last) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy     = (r_state != S_IDLE);
        o_cmd.load   = start && (r_state == S_IDLE);
        o_cmd.walk   = (r_state == S_WALK);
        o_cmd.commit = (r_state == S_COMMIT);
    end

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_status.rd_last) |=> (r_state == S_DRAIN))
        else $error("walk did not end after last slot");

    a_load_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_WALK && !$past(busy)))
        else $error("accepted transfer did not start a walk");

endmodule

/* rtl/core/nlt_dp.sv */
// Datapath: config registers, slot memory, walk pipeline and result register.
`timescale 1ns / 1ps

module nlt_dp
    import nlt_pkg::*;
#(
    parameter int ENTRIES = NLT_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_nlt_item   i_item,
    input  t_nlt_cmd    i_cmd,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_nlt_status o_status,
    output t_nlt_result o_result,
    output logic        o_done
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    function automatic logic [4:0] sat5(input logic [CW-1:0] v);
        logic [CW+4:0] w;
        w = (CW + 5)'(v);
        return (w > (CW + 5)'(31)) ? 5'd31 : w[4:0];
    endfunction

    logic [15:0]   r_period;
    logic [7:0]    r_deg_misses;
    logic [7:0]    r_dead_misses;
    logic [23:0]   r_deg_thr;
    logic [23:0]   r_dead_thr;

    logic [1:0]    r_op;
    logic [63:0]   r_key;
    logic [31:0]   r_now;

    logic [IW-1:0] r_rd_idx;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    t_nlt_slot     r_rdata;
    t_nlt_slot     mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [1:0]    r_hit_state;
    logic [31:0]   r_hit_seen;
    logic          r_free_ok;
    logic [IW-1:0] r_free_idx;
    logic [CW-1:0] r_chg;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_alive;
    logic [CW-1:0] n_alive;

    t_nlt_result   r_result;
    t_nlt_result   n_result;
    logic          r_done;

    logic          v_proc;
    logic [31:0]   age;
    logic [1:0]    ns;
    logic          w_we;
    logic [IW-1:0] w_addr;
    t_nlt_slot     w_data;

    // config and thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_MS_RST;
            r_deg_misses  <= DEGRADED_MISSES_RST;
            r_dead_misses <= DEAD_MISSES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIOD_MS:       r_period      <= i_cfg_data;
                CFG_DEGRADED_MISSES: r_deg_misses  <= i_cfg_data[7:0];
                CFG_DEAD_MISSES:     r_dead_misses <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg_thr  <= r_period * r_deg_misses;
        r_dead_thr <= r_period * r_dead_misses;
    end

    // aging and write port
    always_comb begin
        v_proc = r_valid[r_pidx];
        age    = r_now - r_rdata.last_seen;
        if (age >= {8'd0, r_dead_thr}) begin
            ns = ST_DEAD;
        end else if (age >= {8'd0, r_deg_thr}) begin
            ns = ST_DEGRADED;
        end else begin
            ns = ST_OK;
        end

        w_we   = 1'b0;
        w_addr = r_pidx;
        w_data = r_rdata;
        w_data.state = ns;
        if (r_pv && r_op == OP_TICK && v_proc) begin
            w_we = 1'b1;
        end else if (i_cmd.commit && r_op == OP_OBSERVE && (r_hit || r_free_ok)) begin
            w_we   = 1'b1;
            w_addr = r_hit ? r_hit_idx : r_free_idx;
            w_data = '{key: r_key, last_seen: r_now, state: ST_OK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_data;
        end
        if (i_cmd.walk) begin
            r_rdata <= mem[r_rd_idx];
        end
    end

    assign o_status.rd_last = (r_rd_idx == IW'(ENTRIES - 1));

    // walk pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_pv <= i_cmd.walk;
            if (i_cmd.load) begin
                r_rd_idx <= '0;
            end else if (i_cmd.walk) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_rd_idx;
        if (i_cmd.load) begin
            r_op      <= i_item.op;
            r_key     <= i_item.key;
            r_now     <= i_item.now_ms;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_chg     <= '0;
            r_cnt     <= '0;
        end else if (r_pv) begin
            if (v_proc && r_rdata.key == r_key && !r_hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_pidx;
                r_hit_state <= r_rdata.state;
                r_hit_seen  <= r_rdata.last_seen;
            end
            if (!v_proc && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_pidx;
            end
            if (v_proc && ns != r_rdata.state) begin
                r_chg <= r_chg + CW'(1);
            end
            if (v_proc && ns != ST_DEAD) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // commit
    always_comb begin
        n_alive  = r_alive;
        n_result = '0;
        unique case (r_op)
            OP_OBSERVE: begin
                if (r_hit) begin
                    n_result.found     = 1'b1;
                    n_result.last_seen = r_now;
                    if (r_hit_state == ST_DEAD) n_alive = r_alive + CW'(1);
                end else if (r_free_ok) begin
                    n_result.is_new    = 1'b1;
                    n_result.last_seen = r_now;
                    n_alive            = r_alive + CW'(1);
                end else begin
                    n_result.table_full = 1'b1;
                end
            end
            OP_TICK: begin
                n_result.transitions = sat5(r_chg);
                n_alive              = r_cnt;
            end
            OP_LOOKUP: begin
                if (r_hit) begin
                    n_result.found       = 1'b1;
                    n_result.entry_state = r_hit_state;
                    n_result.last_seen   = r_hit_seen;
                end
            end
            default: ;
        endcase
        n_result.alive_count = sat5(n_alive);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_alive <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_alive <= n_alive;
                if (r_op == OP_OBSERVE && !r_hit && r_free_ok) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

    a_done_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(i_cmd.commit))
        else $error("result strobe without commit");

    a_alive_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive <= CW'(ENTRIES))
        else $error("live count exceeds table size");

    a_no_commit_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit && (r_pv || i_cmd.walk)))
        else $error("commit overlaps the walk pipeline");

endmodule

/* rtl/core/neighbor_liveness_table.sv */
// Neighbor liveness table top level: sequencer plus slot datapath.
// The result strobe is registered from the commit state, which follows the walk and drain states.
// A new item is taken only while idle, and every item walks all slots once,
// one slot per cycle through the single read port of the slot memory.
// Reset: synchronous, clears valid bits, live count and config to defaults.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module neighbor_liveness_table
    import nlt_pkg::*;
#(
    parameter int ENTRIES = NLT_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_nlt_item   i_item,
    output logic        o_done,
    output t_nlt_result o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_nlt_cmd    cmd;
    t_nlt_status status;

    assign o_cfg_ready = 1'b1;

    nlt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    nlt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_result    (o_result),
        .o_done      (o_done)
    );

endmodule
